// ===== hdl/w3s_pkg.sv =====
// ----------------------------------------------------------------------------
// w3s_pkg
// shared codes, register indexes and fixed field widths of the 3d wave stepper
// ----------------------------------------------------------------------------
package w3s_pkg;

  localparam int unsigned COORD_W    = 5;
  localparam int unsigned PORT_AMP_W = 24;
  localparam int unsigned OP_W       = 2;
  localparam int unsigned K_W        = 16;
  localparam int unsigned D_W        = 17;
  localparam int unsigned SIZE_W     = 6;
  localparam int unsigned FRAC_W     = 16;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 17;

  localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
  localparam logic [OP_W-1:0] OP_READ  = 2'd1;
  localparam logic [OP_W-1:0] OP_STEP  = 2'd2;
  localparam logic [OP_W-1:0] OP_NONE  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_K      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DAMP   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_X = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Y = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Z = 3'd4;

  localparam logic [K_W-1:0]    K_RESET    = 16'd0;
  localparam logic [D_W-1:0]    DAMP_RESET = 17'd65536;
  localparam logic [SIZE_W-1:0] SIZE_RESET = 6'd32;

endpackage

// ===== hdl/w3s_calc.sv =====
// ----------------------------------------------------------------------------
// w3s_calc
// three-stage update pipe: courant product, sum, damping product, saturation
// ----------------------------------------------------------------------------
module w3s_calc #(
  parameter int unsigned AMP_BITS = 24
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              valid_i,
  input  logic signed [AMP_BITS+3:0]        lap_i,
  input  logic signed [AMP_BITS-1:0]        cur_i,
  input  logic signed [AMP_BITS-1:0]        prev_i,
  input  logic        [w3s_pkg::K_W-1:0]    k_i,
  input  logic        [w3s_pkg::D_W-1:0]    damp_i,
  output logic                              valid_o,
  output logic signed [AMP_BITS-1:0]        next_o,
  output logic                              sat_o
);

  localparam int unsigned LW  = AMP_BITS + 4;
  localparam int unsigned P1W = LW + w3s_pkg::K_W + 1;
  localparam int unsigned TW  = P1W - w3s_pkg::FRAC_W;
  localparam int unsigned CW  = AMP_BITS + 2;
  localparam int unsigned RW  = AMP_BITS + 6;
  localparam int unsigned P2W = RW + w3s_pkg::D_W + 1;
  localparam int unsigned NW  = P2W - w3s_pkg::FRAC_W;
  localparam logic signed [NW-1:0] AMAX = (NW'(1) <<< (AMP_BITS - 1)) - NW'(1);
  localparam logic signed [NW-1:0] AMIN = -(NW'(1) <<< (AMP_BITS - 1));

  logic signed [P1W-1:0] prod1_q, prod1_d, half1;
  logic signed [CW-1:0]  cur2_q, cur2_d;
  logic signed [TW-1:0]  t_s;
  logic signed [RW-1:0]  r_q, r_d;
  logic signed [P2W-1:0] prod2_q, prod2_d, half2;
  logic signed [NW-1:0]  n_s;
  logic                  v1_q, v2_q, v3_q;

  assign half1   = P1W'(1) <<< (w3s_pkg::FRAC_W - 1);
  assign half2   = P2W'(1) <<< (w3s_pkg::FRAC_W - 1);
  assign prod1_d = P1W'($signed({1'b0, k_i})) * P1W'(lap_i);
  assign cur2_d  = (CW'(cur_i) <<< 1) - CW'(prev_i);

  always_comb begin
    logic signed [P1W-1:0] s1;
    s1  = prod1_q + half1;
    t_s = $signed(s1[P1W-1:w3s_pkg::FRAC_W]);
  end

  assign r_d     = RW'(cur2_q) + RW'(t_s);
  assign prod2_d = P2W'($signed({1'b0, damp_i})) * P2W'(r_q);

  always_comb begin
    logic signed [P2W-1:0] s2;
    s2  = prod2_q + half2;
    n_s = $signed(s2[P2W-1:w3s_pkg::FRAC_W]);
    if (n_s > AMAX) begin
      next_o = AMAX[AMP_BITS-1:0];
      sat_o  = 1'b1;
    end else if (n_s < AMIN) begin
      next_o = AMIN[AMP_BITS-1:0];
      sat_o  = 1'b1;
    end else begin
      next_o = n_s[AMP_BITS-1:0];
      sat_o  = 1'b0;
    end
  end

  assign valid_o = v3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    prod1_q <= prod1_d;
    cur2_q  <= cur2_d;
    r_q     <= r_d;
    prod2_q <= prod2_d;
  end

endmodule

// ===== hdl/wave_3d_stencil_step.sv =====
// ----------------------------------------------------------------------------
// wave_3d_stencil_step
// 3d wave-equation stepper, 7-point stencil over two amplitude memories
// ----------------------------------------------------------------------------
// command channel: a beat is taken when start_i is high and busy_o is low.
// opcode write loads both amplitudes and the wall bit of one cell, read
// returns them, step advances the grid in use by one time step.
// every command gives one result beat: done_o high for exactly one cycle with
// read_now_o, read_before_o, read_wall_o and clipped_o; the receiver cannot
// stall, so results are never held.
// a step walks the grid in use one cell at a time: a face cell is written
// to zero in the scan state, an interior wall cell ends once its wall bit
// is read, an interior open cell reads neighbours on the two read ports of
// the current memory (scan, r1, r2, r3), then runs the 3-stage multiply pipe.
// the two stores exchange roles by a bank select bit, not by copying.
// configuration: cfg_valid_i/cfg_ready_o write port, always ready; write only
// while idle.
// reset: a clearing pass zeroes all MAX_X*MAX_Y*MAX_Z cells of both amplitude
// memories and the wall memory, one cell a cycle; busy_o stays high meanwhile.
// ----------------------------------------------------------------------------
module wave_3d_stencil_step #(
  parameter int unsigned MAX_X    = 32,
  parameter int unsigned MAX_Y    = 32,
  parameter int unsigned MAX_Z    = 32,
  parameter int unsigned AMP_BITS = 24
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  output logic                                 busy_o,
  input  logic [w3s_pkg::OP_W-1:0]             opcode_i,
  input  logic [w3s_pkg::COORD_W-1:0]          cell_x_i,
  input  logic [w3s_pkg::COORD_W-1:0]          cell_y_i,
  input  logic [w3s_pkg::COORD_W-1:0]          cell_z_i,
  input  logic signed [w3s_pkg::PORT_AMP_W-1:0] now_value_i,
  input  logic signed [w3s_pkg::PORT_AMP_W-1:0] before_value_i,
  input  logic                                 is_wall_i,
  output logic                                 done_o,
  output logic signed [w3s_pkg::PORT_AMP_W-1:0] read_now_o,
  output logic signed [w3s_pkg::PORT_AMP_W-1:0] read_before_o,
  output logic                                 read_wall_o,
  output logic                                 clipped_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [w3s_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [w3s_pkg::CFG_DATA_W-1:0]       cfg_data_i
);

  localparam int unsigned CELLS = MAX_X * MAX_Y * MAX_Z;
  localparam int unsigned AW    = $clog2(CELLS);
  localparam int unsigned XW    = $clog2(MAX_X);
  localparam int unsigned YW    = $clog2(MAX_Y);
  localparam int unsigned ZW    = $clog2(MAX_Z);
  localparam int unsigned SUMW  = AMP_BITS + 3;
  localparam int unsigned LW    = AMP_BITS + 4;
  localparam int unsigned PW    = w3s_pkg::PORT_AMP_W;
  localparam logic [AW-1:0] STRIDE_X = AW'(MAX_Y * MAX_Z);
  localparam logic [AW-1:0] STRIDE_Y = AW'(MAX_Z);
  localparam logic [AW-1:0] LAST_CELL = AW'(CELLS - 1);
  localparam logic signed [32:0] AMAX = (33'sd1 <<< (AMP_BITS - 1)) - 33'sd1;
  localparam logic signed [32:0] AMIN = -(33'sd1 <<< (AMP_BITS - 1));

  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_RD   = 4'd2;
  localparam logic [3:0] S_SCAN = 4'd3;
  localparam logic [3:0] S_R1   = 4'd4;
  localparam logic [3:0] S_R2   = 4'd5;
  localparam logic [3:0] S_R3   = 4'd6;
  localparam logic [3:0] S_R4   = 4'd7;
  localparam logic [3:0] S_CALC = 4'd8;

  logic signed [AMP_BITS-1:0] mem_a [CELLS];
  logic signed [AMP_BITS-1:0] mem_b [CELLS];
  logic                       wall_mem [CELLS];

  logic [3:0]                 state_q, state_d;
  logic [AW-1:0]              clr_q, clr_d;
  logic [XW-1:0]              x_q, x_d;
  logic [YW-1:0]              y_q, y_d;
  logic [ZW-1:0]              z_q, z_d;
  logic                       sel_q, sel_d;
  logic                       clip_q, clip_d;
  logic                       inside_q, inside_d;
  logic                       done_q, done_d;
  logic signed [PW-1:0]       res_now_q, res_now_d, res_before_q, res_before_d;
  logic                       res_wall_q, res_wall_d, res_clip_q, res_clip_d;
  logic [w3s_pkg::K_W-1:0]    k_q;
  logic [w3s_pkg::D_W-1:0]    damp_q;
  logic [w3s_pkg::SIZE_W-1:0] size_x_q, size_y_q, size_z_q;
  logic signed [AMP_BITS-1:0] cur_q, cur_d, prev_q, prev_d;
  logic signed [SUMW-1:0]     acc_q, acc_d;

  logic [AW-1:0]              op_addr, cell_addr, ra0, ra1, wa;
  logic signed [AMP_BITS-1:0] rd0_a, rd1_a, rd0_b, rd1_b;
  logic                       rd_w;
  logic                       we_a, we_b, we_w, wd_w;
  logic signed [AMP_BITS-1:0] wd_a, wd_b;
  logic signed [AMP_BITS-1:0] now0, now1, prev0;
  logic signed [AMP_BITS-1:0] now_clamped, before_clamped;
  logic                       accept, op_inside, is_face, last_cell;
  logic [XW-1:0]              x_last;
  logic [YW-1:0]              y_last;
  logic [ZW-1:0]              z_last;
  logic signed [LW-1:0]       lap;
  logic                       calc_start, calc_valid, calc_sat;
  logic signed [AMP_BITS-1:0] calc_next;

  function automatic logic [8:0] use_size(input logic [w3s_pkg::SIZE_W-1:0] v,
                                          input logic [8:0] maxv);
    logic [8:0] e;
    e = 9'(v);
    if (e < 9'd3) begin
      return 9'd3;
    end else if (e > maxv) begin
      return maxv;
    end
    return e;
  endfunction

  function automatic logic signed [AMP_BITS-1:0] clamp_in(input logic signed [PW-1:0] v);
    logic signed [32:0] e;
    e = 33'(v);
    if (e > AMAX) begin
      return AMAX[AMP_BITS-1:0];
    end else if (e < AMIN) begin
      return AMIN[AMP_BITS-1:0];
    end
    return e[AMP_BITS-1:0];
  endfunction

  assign x_last = XW'(use_size(size_x_q, 9'(MAX_X)) - 9'd1);
  assign y_last = YW'(use_size(size_y_q, 9'(MAX_Y)) - 9'd1);
  assign z_last = ZW'(use_size(size_z_q, 9'(MAX_Z)) - 9'd1);

  assign accept    = start_i && !busy_o;
  assign op_inside = (int'(cell_x_i) < MAX_X) && (int'(cell_y_i) < MAX_Y) &&
                     (int'(cell_z_i) < MAX_Z);
  assign op_addr   = AW'(cell_x_i) * STRIDE_X + AW'(cell_y_i) * STRIDE_Y + AW'(cell_z_i);
  assign cell_addr = AW'(x_q) * STRIDE_X + AW'(y_q) * STRIDE_Y + AW'(z_q);
  assign is_face   = (x_q == '0) || (x_q == x_last) || (y_q == '0) || (y_q == y_last) ||
                     (z_q == '0) || (z_q == z_last);
  assign last_cell = (x_q == x_last) && (y_q == y_last) && (z_q == z_last);

  assign now_clamped    = clamp_in(now_value_i);
  assign before_clamped = clamp_in(before_value_i);

  assign now0  = sel_q ? rd0_b : rd0_a;
  assign now1  = sel_q ? rd1_b : rd1_a;
  assign prev0 = sel_q ? rd0_a : rd0_b;

  assign lap = LW'(acc_q) + LW'(now0) - ((LW'(cur_q) <<< 2) + (LW'(cur_q) <<< 1));
  assign calc_start = (state_q == S_R4);

  w3s_calc #(
    .AMP_BITS(AMP_BITS)
  ) u_calc (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(calc_start),
    .lap_i  (lap),
    .cur_i  (cur_q),
    .prev_i (prev_q),
    .k_i    (k_q),
    .damp_i (damp_q),
    .valid_o(calc_valid),
    .next_o (calc_next),
    .sat_o  (calc_sat)
  );

  // read port addresses
  always_comb begin
    ra0 = cell_addr;
    ra1 = cell_addr;
    unique case (state_q)
      S_SCAN: begin
        ra1 = cell_addr - STRIDE_X;
      end
      S_R1: begin
        ra0 = cell_addr + STRIDE_X;
        ra1 = cell_addr - STRIDE_Y;
      end
      S_R2: begin
        ra0 = cell_addr + STRIDE_Y;
        ra1 = cell_addr - AW'(1);
      end
      S_R3: begin
        ra0 = cell_addr + AW'(1);
      end
      S_IDLE: begin
        ra0 = op_addr;
      end
      default: begin
      end
    endcase
  end

  // write port
  always_comb begin
    we_a = 1'b0;
    we_b = 1'b0;
    we_w = 1'b0;
    wa   = cell_addr;
    wd_a = '0;
    wd_b = '0;
    wd_w = 1'b0;
    unique case (state_q)
      S_CLR: begin
        we_a = 1'b1;
        we_b = 1'b1;
        we_w = 1'b1;
        wa   = clr_q;
      end
      S_IDLE: begin
        wa = op_addr;
        if (accept && opcode_i == w3s_pkg::OP_WRITE && op_inside) begin
          we_a = 1'b1;
          we_b = 1'b1;
          we_w = 1'b1;
          wd_a = sel_q ? before_clamped : now_clamped;
          wd_b = sel_q ? now_clamped : before_clamped;
          wd_w = is_wall_i;
        end
      end
      S_SCAN: begin
        if (is_face) begin
          we_a = sel_q;
          we_b = !sel_q;
        end
      end
      S_CALC: begin
        if (calc_valid) begin
          we_a = sel_q;
          we_b = !sel_q;
          wd_a = calc_next;
          wd_b = calc_next;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we_a) begin
      mem_a[wa] <= wd_a;
    end
    if (we_b) begin
      mem_b[wa] <= wd_b;
    end
    if (we_w) begin
      wall_mem[wa] <= wd_w;
    end
    rd0_a <= mem_a[ra0];
    rd1_a <= mem_a[ra1];
    rd0_b <= mem_b[ra0];
    rd1_b <= mem_b[ra1];
    rd_w  <= wall_mem[ra0];
  end

  // sequencer
  always_comb begin
    logic advance;
    advance      = 1'b0;
    state_d      = state_q;
    clr_d        = clr_q;
    x_d          = x_q;
    y_d          = y_q;
    z_d          = z_q;
    sel_d        = sel_q;
    clip_d       = clip_q;
    inside_d     = inside_q;
    done_d       = 1'b0;
    res_now_d    = '0;
    res_before_d = '0;
    res_wall_d   = 1'b0;
    res_clip_d   = 1'b0;
    cur_d        = cur_q;
    prev_d       = prev_q;
    acc_d        = acc_q;
    unique case (state_q)
      S_CLR: begin
        clr_d = clr_q + AW'(1);
        if (clr_q == LAST_CELL) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          inside_d = op_inside;
          unique case (opcode_i)
            w3s_pkg::OP_READ: begin
              state_d = S_RD;
            end
            w3s_pkg::OP_STEP: begin
              state_d = S_SCAN;
              x_d     = '0;
              y_d     = '0;
              z_d     = '0;
              clip_d  = 1'b0;
            end
            w3s_pkg::OP_WRITE, w3s_pkg::OP_NONE: begin
              done_d = 1'b1;
            end
          endcase
        end
      end
      S_RD: begin
        state_d = S_IDLE;
        done_d  = 1'b1;
        if (inside_q) begin
          res_now_d    = PW'(now0);
          res_before_d = PW'(prev0);
          res_wall_d   = rd_w;
        end
      end
      S_SCAN: begin
        if (is_face) begin
          advance = 1'b1;
        end else begin
          state_d = S_R1;
        end
      end
      S_R1: begin
        if (rd_w) begin
          advance = 1'b1;
        end else begin
          cur_d   = now0;
          prev_d  = prev0;
          acc_d   = SUMW'(now1);
          state_d = S_R2;
        end
      end
      S_R2: begin
        acc_d   = acc_q + SUMW'(now0) + SUMW'(now1);
        state_d = S_R3;
      end
      S_R3: begin
        acc_d   = acc_q + SUMW'(now0) + SUMW'(now1);
        state_d = S_R4;
      end
      S_R4: begin
        state_d = S_CALC;
      end
      S_CALC: begin
        if (calc_valid) begin
          clip_d  = clip_q | calc_sat;
          advance = 1'b1;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    if (advance) begin
      if (last_cell) begin
        state_d    = S_IDLE;
        sel_d      = !sel_q;
        done_d     = 1'b1;
        res_clip_d = clip_d;
      end else begin
        state_d = S_SCAN;
        if (z_q == z_last) begin
          z_d = '0;
          if (y_q == y_last) begin
            y_d = '0;
            x_d = x_q + XW'(1);
          end else begin
            y_d = y_q + YW'(1);
          end
        end else begin
          z_d = z_q + ZW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLR;
      clr_q    <= '0;
      x_q      <= '0;
      y_q      <= '0;
      z_q      <= '0;
      sel_q    <= 1'b0;
      clip_q   <= 1'b0;
      inside_q <= 1'b0;
      done_q   <= 1'b0;
      k_q      <= w3s_pkg::K_RESET;
      damp_q   <= w3s_pkg::DAMP_RESET;
      size_x_q <= w3s_pkg::SIZE_RESET;
      size_y_q <= w3s_pkg::SIZE_RESET;
      size_z_q <= w3s_pkg::SIZE_RESET;
    end else begin
      state_q  <= state_d;
      clr_q    <= clr_d;
      x_q      <= x_d;
      y_q      <= y_d;
      z_q      <= z_d;
      sel_q    <= sel_d;
      clip_q   <= clip_d;
      inside_q <= inside_d;
      done_q   <= done_d;
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          w3s_pkg::CFG_K:      k_q      <= cfg_data_i[w3s_pkg::K_W-1:0];
          w3s_pkg::CFG_DAMP:   damp_q   <= cfg_data_i[w3s_pkg::D_W-1:0];
          w3s_pkg::CFG_SIZE_X: size_x_q <= cfg_data_i[w3s_pkg::SIZE_W-1:0];
          w3s_pkg::CFG_SIZE_Y: size_y_q <= cfg_data_i[w3s_pkg::SIZE_W-1:0];
          w3s_pkg::CFG_SIZE_Z: size_z_q <= cfg_data_i[w3s_pkg::SIZE_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_now_q    <= res_now_d;
    res_before_q <= res_before_d;
    res_wall_q   <= res_wall_d;
    res_clip_q   <= res_clip_d;
    cur_q        <= cur_d;
    prev_q       <= prev_d;
    acc_q        <= acc_d;
  end

  assign busy_o        = (state_q != S_IDLE);
  assign done_o        = done_q;
  assign read_now_o    = res_now_q;
  assign read_before_o = res_before_q;
  assign read_wall_o   = res_wall_q;
  assign clipped_o     = res_clip_q;
  assign cfg_ready_o   = 1'b1;

endmodule

// ===== verif/wave_3d_stencil_step_tb.sv =====
// ----------------------------------------------------------------------------
// wave_3d_stencil_step_tb
// self-checking testbench of the 3d wave-equation stepper: a grid model in a
// scoreboard class predicts every result beat from the accepted commands and
// the register settings; directed corner commands are followed by random
// phases over several register settings, with random gaps on the command side
// ----------------------------------------------------------------------------
module wave_3d_stencil_step_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned GRID     = 32;
  localparam int unsigned CELLS    = GRID * GRID * GRID;
  localparam longint      AMP_HI   = 64'sd8388607;
  localparam longint      AMP_LO   = -64'sd8388608;
  localparam longint      HALF     = 64'sd32768;
  localparam int unsigned LIMIT    = 8000000;
  localparam int unsigned PHASES   = 9;

  typedef struct packed {
    logic signed [w3s_pkg::PORT_AMP_W-1:0] rd_now;
    logic signed [w3s_pkg::PORT_AMP_W-1:0] rd_before;
    logic                                  rd_wall;
    logic                                  clip;
  } grid_result_t;

  class wave_grid_model;
    logic signed [w3s_pkg::PORT_AMP_W-1:0] amp [2][CELLS];
    bit                                    wall [CELLS];
    bit                                    bank;
    logic [w3s_pkg::K_W-1:0]               k_val;
    logic [w3s_pkg::D_W-1:0]               damp_val;
    logic [w3s_pkg::SIZE_W-1:0]            sz [3];
    grid_result_t                          awaited [$];
    int unsigned                           errors;
    int unsigned                           checked;
    int unsigned                           clips;

    function new();
      foreach (wall[i]) begin
        wall[i] = 0;
        amp[0][i] = '0;
        amp[1][i] = '0;
      end
      bank = 0;
      k_val = w3s_pkg::K_RESET;
      damp_val = w3s_pkg::DAMP_RESET;
      sz[0] = w3s_pkg::SIZE_RESET;
      sz[1] = w3s_pkg::SIZE_RESET;
      sz[2] = w3s_pkg::SIZE_RESET;
    endfunction

    function void set_reg(logic [w3s_pkg::CFG_IDX_W-1:0] idx,
                          logic [w3s_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        w3s_pkg::CFG_K:      k_val = data[w3s_pkg::K_W-1:0];
        w3s_pkg::CFG_DAMP:   damp_val = data[w3s_pkg::D_W-1:0];
        w3s_pkg::CFG_SIZE_X: sz[0] = data[w3s_pkg::SIZE_W-1:0];
        w3s_pkg::CFG_SIZE_Y: sz[1] = data[w3s_pkg::SIZE_W-1:0];
        w3s_pkg::CFG_SIZE_Z: sz[2] = data[w3s_pkg::SIZE_W-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned span(int unsigned a);
      int unsigned v;
      v = sz[a];
      if (v < 3) v = 3;
      if (v > GRID) v = GRID;
      return v;
    endfunction

    function int unsigned at(int unsigned x, int unsigned y, int unsigned z);
      return (x * GRID + y) * GRID + z;
    endfunction

    function bit advance();
      int unsigned w, h, l, c;
      longint cur, sum, lap, t, r, n;
      bit sat;
      w = span(0);
      h = span(1);
      l = span(2);
      sat = 0;
      for (int unsigned x = 1; x + 1 < w; x++)
        for (int unsigned y = 1; y + 1 < h; y++)
          for (int unsigned z = 1; z + 1 < l; z++) begin
            c = at(x, y, z);
            if (!wall[c]) begin
              cur = amp[bank][c];
              sum = longint'(amp[bank][at(x-1, y, z)]) + amp[bank][at(x+1, y, z)]
                  + amp[bank][at(x, y-1, z)] + amp[bank][at(x, y+1, z)]
                  + amp[bank][at(x, y, z-1)] + amp[bank][at(x, y, z+1)];
              lap = sum - 6 * cur;
              t = (longint'(k_val) * lap + HALF) >>> w3s_pkg::FRAC_W;
              r = 2 * cur - longint'(amp[!bank][c]) + t;
              n = (longint'(damp_val) * r + HALF) >>> w3s_pkg::FRAC_W;
              if (n > AMP_HI) begin
                n = AMP_HI;
                sat = 1;
              end else if (n < AMP_LO) begin
                n = AMP_LO;
                sat = 1;
              end
              amp[!bank][c] = n[w3s_pkg::PORT_AMP_W-1:0];
            end
          end
      bank = !bank;
      for (int unsigned x = 0; x < w; x++)
        for (int unsigned y = 0; y < h; y++)
          for (int unsigned z = 0; z < l; z++)
            if (x == 0 || x == w-1 || y == 0 || y == h-1 || z == 0 || z == l-1)
              amp[bank][at(x, y, z)] = '0;
      return sat;
    endfunction

    function void note_command(logic [w3s_pkg::OP_W-1:0] op,
                               logic [w3s_pkg::COORD_W-1:0] x,
                               logic [w3s_pkg::COORD_W-1:0] y,
                               logic [w3s_pkg::COORD_W-1:0] z,
                               logic signed [w3s_pkg::PORT_AMP_W-1:0] nv,
                               logic signed [w3s_pkg::PORT_AMP_W-1:0] bv, logic wl);
      grid_result_t res;
      int unsigned c;
      res = '0;
      c = at(x, y, z);
      case (op)
        w3s_pkg::OP_WRITE: begin
          amp[bank][c] = nv;
          amp[!bank][c] = bv;
          wall[c] = wl;
        end
        w3s_pkg::OP_READ: begin
          res.rd_now = amp[bank][c];
          res.rd_before = amp[!bank][c];
          res.rd_wall = wall[c];
        end
        w3s_pkg::OP_STEP: begin
          res.clip = advance();
          clips += res.clip;
        end
        default: ;
      endcase
      awaited.push_back(res);
    endfunction

    function void check_result(grid_result_t got);
      grid_result_t want;
      if (awaited.size() == 0) begin
        $display("%0t: unexpected result beat %h", $time, got);
        errors++;
        return;
      end
      want = awaited.pop_front();
      checked++;
      if (got.rd_now !== want.rd_now) begin
        $display("%0t: read_now expected %0d actual %0d", $time, want.rd_now, got.rd_now);
        errors++;
      end
      if (got.rd_before !== want.rd_before) begin
        $display("%0t: read_before expected %0d actual %0d", $time,
                 want.rd_before, got.rd_before);
        errors++;
      end
      if (got.rd_wall !== want.rd_wall) begin
        $display("%0t: read_wall expected %0b actual %0b", $time, want.rd_wall, got.rd_wall);
        errors++;
      end
      if (got.clip !== want.clip) begin
        $display("%0t: clipped expected %0b actual %0b", $time, want.clip, got.clip);
        errors++;
      end
    endfunction
  endclass

  logic                                   clk_i;
  logic                                   rst_ni;
  logic                                   start_i;
  logic                                   busy_o;
  logic [w3s_pkg::OP_W-1:0]               opcode_i;
  logic [w3s_pkg::COORD_W-1:0]            cell_x_i;
  logic [w3s_pkg::COORD_W-1:0]            cell_y_i;
  logic [w3s_pkg::COORD_W-1:0]            cell_z_i;
  logic signed [w3s_pkg::PORT_AMP_W-1:0]  now_value_i;
  logic signed [w3s_pkg::PORT_AMP_W-1:0]  before_value_i;
  logic                                   is_wall_i;
  logic                                   done_o;
  logic signed [w3s_pkg::PORT_AMP_W-1:0]  read_now_o;
  logic signed [w3s_pkg::PORT_AMP_W-1:0]  read_before_o;
  logic                                   read_wall_o;
  logic                                   clipped_o;
  logic                                   cfg_valid_i;
  logic                                   cfg_ready_o;
  logic [w3s_pkg::CFG_IDX_W-1:0]          cfg_index_i;
  logic [w3s_pkg::CFG_DATA_W-1:0]         cfg_data_i;

  wave_grid_model grid = new();
  int unsigned    cycles;
  int unsigned    commands;
  bit             tail;

  wave_3d_stencil_step uut (.*);

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("%0t: timeout with %0d results awaited", $time, grid.awaited.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && done_o)
      grid.check_result({read_now_o, read_before_o, read_wall_o, clipped_o});
  end

  task automatic send_cmd(logic [w3s_pkg::OP_W-1:0] op, int unsigned x, int unsigned y,
                          int unsigned z, logic signed [w3s_pkg::PORT_AMP_W-1:0] nv,
                          logic signed [w3s_pkg::PORT_AMP_W-1:0] bv, logic wl);
    start_i <= 1'b1;
    opcode_i <= op;
    cell_x_i <= x[w3s_pkg::COORD_W-1:0];
    cell_y_i <= y[w3s_pkg::COORD_W-1:0];
    cell_z_i <= z[w3s_pkg::COORD_W-1:0];
    now_value_i <= nv;
    before_value_i <= bv;
    is_wall_i <= wl;
    do @(posedge clk_i); while (busy_o);
    grid.note_command(op, x[w3s_pkg::COORD_W-1:0], y[w3s_pkg::COORD_W-1:0],
                      z[w3s_pkg::COORD_W-1:0], nv, bv, wl);
    commands++;
    if (!tail && $urandom_range(0, 3) == 0) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    start_i <= 1'b0;
    while (grid.awaited.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [w3s_pkg::CFG_IDX_W-1:0] idx, int unsigned data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data[w3s_pkg::CFG_DATA_W-1:0];
    do @(posedge clk_i); while (!cfg_ready_o);
    grid.set_reg(idx, data[w3s_pkg::CFG_DATA_W-1:0]);
  endtask

  function automatic logic signed [w3s_pkg::PORT_AMP_W-1:0] rand_amp();
    if ($urandom_range(0, 1))
      return w3s_pkg::PORT_AMP_W'($signed($urandom_range(0, 262143)) - 131072);
    return w3s_pkg::PORT_AMP_W'($urandom());
  endfunction

  task automatic rand_cmd();
    int unsigned sel, x, y, z;
    sel = $urandom_range(0, 99);
    x = $urandom_range(0, grid.span(0) - 1);
    y = $urandom_range(0, grid.span(1) - 1);
    z = $urandom_range(0, grid.span(2) - 1);
    if (sel >= 90) begin
      x = $urandom_range(0, GRID - 1);
      y = $urandom_range(0, GRID - 1);
      z = $urandom_range(0, GRID - 1);
    end
    if (sel < 45 || (sel >= 90 && sel < 94))
      send_cmd(w3s_pkg::OP_WRITE, x, y, z, rand_amp(), rand_amp(),
               $urandom_range(0, 3) == 0);
    else if (sel < 75 || (sel >= 94 && sel < 98))
      send_cmd(w3s_pkg::OP_READ, x, y, z, rand_amp(), rand_amp(), $urandom_range(0, 1));
    else if (sel < 90)
      send_cmd(w3s_pkg::OP_STEP, x, y, z, rand_amp(), rand_amp(), $urandom_range(0, 1));
    else
      send_cmd(w3s_pkg::OP_NONE, x, y, z, rand_amp(), rand_amp(), $urandom_range(0, 1));
  endtask

  initial begin
    int unsigned big, kv, dv;
    int unsigned szv [3];
    cycles = 0;
    commands = 0;
    tail = 0;
    rst_ni = 1'b0;
    start_i = 1'b0;
    opcode_i = w3s_pkg::OP_NONE;
    cell_x_i = '0;
    cell_y_i = '0;
    cell_z_i = '0;
    now_value_i = '0;
    before_value_i = '0;
    is_wall_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = w3s_pkg::CFG_K;
    cfg_data_i = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings, full grid
    send_cmd(w3s_pkg::OP_READ, 5, 6, 7, '0, '0, 1'b0);
    send_cmd(w3s_pkg::OP_WRITE, 0, 0, 0, 24'sh7fffff, 24'sh800000, 1'b0);
    send_cmd(w3s_pkg::OP_WRITE, 31, 31, 31, 24'sh800000, 24'sh7fffff, 1'b1);
    send_cmd(w3s_pkg::OP_WRITE, 1, 1, 1, 24'sh010000, 24'sh008000, 1'b0);
    send_cmd(w3s_pkg::OP_WRITE, 2, 1, 1, 24'sh020000, 24'sh000000, 1'b1);
    send_cmd(w3s_pkg::OP_READ, 0, 0, 0, '0, '0, 1'b0);
    send_cmd(w3s_pkg::OP_READ, 31, 31, 31, '0, '0, 1'b0);
    send_cmd(w3s_pkg::OP_NONE, 21, 10, 31, 24'sh7fffff, 24'sh7fffff, 1'b1);
    send_cmd(w3s_pkg::OP_STEP, 0, 0, 0, '0, '0, 1'b0);
    send_cmd(w3s_pkg::OP_READ, 1, 1, 1, '0, '0, 1'b0);
    send_cmd(w3s_pkg::OP_READ, 2, 1, 1, '0, '0, 1'b0);
    send_cmd(w3s_pkg::OP_READ, 31, 31, 31, '0, '0, 1'b0);
    drain();

    // smallest grid, gain above one, clipping in the single interior cell
    write_reg(w3s_pkg::CFG_K, 65535);
    write_reg(w3s_pkg::CFG_DAMP, 131071);
    write_reg(w3s_pkg::CFG_SIZE_X, 0);
    write_reg(w3s_pkg::CFG_SIZE_Y, 3);
    write_reg(w3s_pkg::CFG_SIZE_Z, 2);
    cfg_valid_i <= 1'b0;
    send_cmd(w3s_pkg::OP_WRITE, 1, 1, 1, 24'sh7fffff, 24'sh800000, 1'b0);
    send_cmd(w3s_pkg::OP_WRITE, 1, 1, 0, 24'sh100000, 24'sh000000, 1'b0);
    send_cmd(w3s_pkg::OP_WRITE, 20, 9, 30, 24'sh123456, 24'shfedcba, 1'b1);
    send_cmd(w3s_pkg::OP_STEP, 0, 0, 0, '0, '0, 1'b0);
    send_cmd(w3s_pkg::OP_READ, 1, 1, 1, '0, '0, 1'b0);
    send_cmd(w3s_pkg::OP_READ, 1, 1, 0, '0, '0, 1'b0);
    send_cmd(w3s_pkg::OP_READ, 20, 9, 30, '0, '0, 1'b0);
    drain();

    for (int unsigned ph = 0; ph < PHASES; ph++) begin
      tail = (ph == PHASES - 1);
      kv = (ph % 3 == 0) ? 65535 : (ph % 3 == 1) ? 0 : $urandom_range(0, 65535);
      case (ph % 4)
        0: dv = 0;
        1: dv = 65536;
        2: dv = 131071;
        default: dv = $urandom_range(40000, 70000);
      endcase
      big = $urandom_range(0, 2);
      for (int a = 0; a < 3; a++)
        szv[a] = (a == big) ? $urandom_range(0, 63) : $urandom_range(0, 7);
      write_reg(w3s_pkg::CFG_K, kv);
      write_reg(w3s_pkg::CFG_DAMP, dv);
      write_reg(w3s_pkg::CFG_SIZE_X, szv[0]);
      write_reg(w3s_pkg::CFG_SIZE_Y, szv[1]);
      write_reg(w3s_pkg::CFG_SIZE_Z, szv[2]);
      cfg_valid_i <= 1'b0;
      repeat (11) rand_cmd();
      drain();
    end

    repeat (20) @(posedge clk_i);
    $display("ran %0d commands over %0d register settings, %0d results checked",
             commands, PHASES + 2, grid.checked);
    $display("%0d steps clipped, %0d mismatches", grid.clips, grid.errors);
    if (grid.errors == 0 && grid.awaited.size() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
